// File: rtl/core/mcpc_pkg.sv
package mcpc_pkg;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  channel;
    logic [47:0] boot_ms;
    logic [31:0] epoch_seconds;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_channel;
    logic [31:0] count;
    logic [63:0] total;
    logic        logged;
    logic [6:0]  log_fill;
    logic        last;
  } out_item_t;

  localparam logic [1:0] OP_EDGE    = 2'd0;
  localparam logic [1:0] OP_CAPTURE = 2'd1;
  localparam logic [1:0] OP_PEEK    = 2'd2;

  localparam int unsigned REG_COUNTING_ENABLED = 0;

  localparam int unsigned CMD_QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_EDGE,
    CMD_CAPTURE,
    CMD_CLEAR,
    CMD_PEEK
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [1:0]  channel;
    logic [47:0] boot_ms;
    logic [31:0] epoch_seconds;
  } cmd_t;

  typedef enum logic {
    BACK_IDLE,
    BACK_WALK
  } back_state_e;

  typedef struct packed {
    logic busy;
  } back_status_t;

endpackage

// File: rtl/core/mcpc_front.sv
module mcpc_front #(
  parameter int CHANNELS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  mcpc_pkg::in_item_t  item_i,
  input  logic                counting_en_i,
  output logic                cmd_valid_o,
  output mcpc_pkg::cmd_t      cmd_o,
  input  logic                cmd_pop_i
);

  localparam int QDEPTH = mcpc_pkg::CMD_QUEUE_DEPTH;
  localparam int QW     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW     = $clog2(QDEPTH + 1);

  mcpc_pkg::cmd_t cmd_new;
  logic           keep;
  logic           enq;

  mcpc_pkg::cmd_t queue_q [QDEPTH];
  logic [QW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  // Classify: drop what has no effect, turn a disabled capture into a clear.
  always_comb begin
    cmd_new.channel       = item_i.channel;
    cmd_new.boot_ms       = item_i.boot_ms;
    cmd_new.epoch_seconds = item_i.epoch_seconds;
    cmd_new.kind          = mcpc_pkg::CMD_EDGE;
    keep                  = 1'b0;
    unique case (item_i.operation)
      mcpc_pkg::OP_EDGE: begin
        cmd_new.kind = mcpc_pkg::CMD_EDGE;
        keep         = counting_en_i && (32'(item_i.channel) < CHANNELS);
      end
      mcpc_pkg::OP_CAPTURE: begin
        cmd_new.kind = counting_en_i ? mcpc_pkg::CMD_CAPTURE : mcpc_pkg::CMD_CLEAR;
        keep         = 1'b1;
      end
      mcpc_pkg::OP_PEEK: begin
        cmd_new.kind = mcpc_pkg::CMD_PEEK;
        keep         = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full        = (cnt_q == CW'(QDEPTH));
  assign enq         = push && !full && keep;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (enq) begin
      wr_ptr_d = (wr_ptr_q == QW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (cmd_pop_i && cmd_valid_o) begin
      rd_ptr_d = (rd_ptr_q == QW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({enq, cmd_pop_i && cmd_valid_o})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// File: rtl/core/mcpc_back.sv
module mcpc_back #(
  parameter int CHANNELS  = 4,
  parameter int LOG_DEPTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  input  mcpc_pkg::cmd_t         cmd_i,
  output logic                   cmd_pop_o,
  output logic                   empty,
  input  logic                   pop,
  output mcpc_pkg::out_item_t    result_o,
  output mcpc_pkg::back_status_t status_o
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int FW = $clog2(LOG_DEPTH + 1);
  localparam int MD = LOG_DEPTH * CHANNELS;
  localparam int AW = (MD > 1) ? $clog2(MD) : 1;

  mcpc_pkg::back_state_e state_q, state_d;

  logic [CW-1:0] idx_q;
  logic          logged_q;
  logic [PW-1:0] wp_q;
  logic [FW-1:0] fill_q;
  logic [AW-1:0] base_q;

  logic [31:0] live_q  [CHANNELS];
  logic [63:0] total_q [CHANNELS];

  logic [31:0] cnt_mem [MD];
  logic [47:0] up_mem  [LOG_DEPTH];
  logic [31:0] ep_mem  [LOG_DEPTH];

  logic                out_valid_q;
  mcpc_pkg::out_item_t out_q;

  logic          out_free;
  logic          start;
  logic          start_capture;
  logic          step;
  logic          step_last;
  logic [CW+1:0] ch_ext;
  logic [CW-1:0] ch_idx;
  logic [CW+1:0] idx_ext;
  logic [FW+6:0] fill_ext;
  logic [31:0]   cur_count;
  logic [63:0]   cur_total;
  logic [AW-1:0] cnt_addr;

  assign out_free  = !out_valid_q || pop;
  assign ch_ext    = (CW + 2)'(cmd_i.channel);
  assign ch_idx    = ch_ext[CW-1:0];
  assign idx_ext   = (CW + 2)'(idx_q);
  assign fill_ext  = (FW + 7)'(fill_q);
  assign cur_count = live_q[idx_q];
  assign cur_total = logged_q ? total_q[idx_q] + 64'(cur_count) : total_q[idx_q];
  assign cnt_addr  = base_q + AW'(idx_q);
  assign step_last = (idx_q == CW'(CHANNELS - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mcpc_pkg::BACK_IDLE: begin
        if (start) begin
          state_d = mcpc_pkg::BACK_WALK;
        end
      end
      mcpc_pkg::BACK_WALK: begin
        if (step && step_last) begin
          state_d = mcpc_pkg::BACK_IDLE;
        end
      end
      default: state_d = mcpc_pkg::BACK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o     = 1'b0;
    start         = 1'b0;
    start_capture = 1'b0;
    step          = 1'b0;
    unique case (state_q)
      mcpc_pkg::BACK_IDLE: begin
        cmd_pop_o     = cmd_valid_i;
        start         = cmd_valid_i && ((cmd_i.kind == mcpc_pkg::CMD_CAPTURE) ||
                                        (cmd_i.kind == mcpc_pkg::CMD_PEEK));
        start_capture = cmd_valid_i && (cmd_i.kind == mcpc_pkg::CMD_CAPTURE);
      end
      mcpc_pkg::BACK_WALK: begin
        step = out_free;
      end
      default: begin
        step = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcpc_pkg::BACK_IDLE;
      idx_q       <= '0;
      logged_q    <= 1'b0;
      wp_q        <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        live_q[i]  <= '0;
        total_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (start) begin
        idx_q    <= '0;
        logged_q <= start_capture;
      end else if (step) begin
        idx_q <= step_last ? '0 : idx_q + 1'b1;
      end
      // Advance the ring before the walk so every result sees the final fill.
      if (start_capture) begin
        wp_q <= (wp_q == PW'(LOG_DEPTH - 1)) ? '0 : wp_q + 1'b1;
        if (fill_q != FW'(LOG_DEPTH)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (cmd_pop_o && (cmd_i.kind == mcpc_pkg::CMD_EDGE)) begin
        live_q[ch_idx] <= live_q[ch_idx] + 32'd1;
      end
      if (cmd_pop_o && (cmd_i.kind == mcpc_pkg::CMD_CLEAR)) begin
        for (int i = 0; i < CHANNELS; i++) begin
          live_q[i] <= '0;
        end
      end
      if (step && logged_q) begin
        live_q[idx_q]  <= '0;
        total_q[idx_q] <= cur_total;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_capture) begin
      base_q <= AW'(32'(wp_q) * CHANNELS);
    end
    if (step) begin
      out_q.out_channel <= idx_ext[1:0];
      out_q.count       <= cur_count;
      out_q.total       <= cur_total;
      out_q.logged      <= logged_q;
      out_q.log_fill    <= fill_ext[6:0];
      out_q.last        <= step_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_capture) begin
      up_mem[wp_q] <= cmd_i.boot_ms;
      ep_mem[wp_q] <= cmd_i.epoch_seconds;
    end
    if (step && logged_q) begin
      cnt_mem[cnt_addr] <= cur_count;
    end
  end

  assign empty         = !out_valid_q;
  assign result_o      = out_q;
  assign status_o.busy = (state_q == mcpc_pkg::BACK_WALK);

endmodule

// File: rtl/core/multi_channel_pulse_counter_logger.sv
// Channel   Direction  Handshake              Payload
// item      in         push / full            in_item_t
// result    out        empty / pop            out_item_t
// config    in         psel/penable/pwrite    counting_enabled at byte 0
//
// An edge updates its live count as it is dispatched in the back end; a capture
// or peek is dispatched and then walks over the channels through one 64-bit
// total adder, one result per cycle unless the walk holds. A two-entry command
// queue sits between front and back.
// Reset clears counts, totals, ring pointer and fill; the log stores are left
// unwritten. The walk holds while the result register is full and not popped.
module multi_channel_pulse_counter_logger #(
  parameter int CHANNELS  = 4,
  parameter int LOG_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  mcpc_pkg::in_item_t  item_i,
  output logic                empty,
  input  logic                pop,
  output mcpc_pkg::out_item_t result_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic                   counting_en_q;
  logic                   cmd_valid;
  mcpc_pkg::cmd_t         cmd;
  logic                   cmd_pop;
  mcpc_pkg::back_status_t back_status;
  logic                   reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (32'(paddr[2]) == mcpc_pkg::REG_COUNTING_ENABLED);
  assign prdata  = reg_sel ? {31'd0, counting_en_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counting_en_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      counting_en_q <= pwdata[0];
    end
  end

  mcpc_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .item_i        (item_i),
    .counting_en_i (counting_en_q),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  mcpc_back #(
    .CHANNELS (CHANNELS),
    .LOG_DEPTH(LOG_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o),
    .status_o    (back_status)
  );

  a_last_is_final_channel : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.last) |-> (result_o.out_channel == 2'(CHANNELS - 1))
  ) else $error("last flag on a result that is not the final channel");

  a_channel_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (32'(result_o.out_channel) < CHANNELS || CHANNELS > 4)
  ) else $error("result reports a channel beyond CHANNELS");

  a_queue_full_only_behind_walk : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    full |-> (back_status.busy || $past(back_status.busy))
  ) else $error("command queue filled while the back end was free");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int NCH          = 4;
  localparam int RING_DEPTH   = 64;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 42;
  localparam int TIMEOUT_NS   = 4_000_000;

  localparam logic [1:0] OP_UNUSED       = 2'd3;
  localparam logic [2:0] ADDR_ENABLE     = 3'(mcpc_pkg::REG_COUNTING_ENABLED * 4);
  localparam logic [2:0] ADDR_UNMAPPED   = 3'd4;

  typedef enum logic {
    ROW_ITEM,
    ROW_REG
  } row_kind_e;

  typedef struct {
    row_kind_e           kind;
    mcpc_pkg::in_item_t  item;
    logic                typed;
    mcpc_pkg::out_item_t tmpl;
    logic [2:0]          addr;
    logic [31:0]         wdata;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  mcpc_pkg::in_item_t  item_i;
  logic                empty;
  logic                pop;
  mcpc_pkg::out_item_t result_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  multi_channel_pulse_counter_logger u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Counter and ring log mirror
  logic        counting_en;
  logic [31:0] cnt_live  [NCH];
  logic [63:0] cnt_total [NCH];
  logic [31:0] cnt_last  [NCH];
  logic [31:0] ring_counts [RING_DEPTH][NCH];
  logic [47:0] ring_uptime [RING_DEPTH];
  logic [31:0] ring_epoch  [RING_DEPTH];
  logic [5:0]  ring_wr;
  logic [6:0]  ring_fill;

  mcpc_pkg::out_item_t pending_results[$];
  dir_row_t            dir_rows[$];

  int errors;
  int items_sent;
  int results_checked;
  int captures_logged;
  int reg_writes;
  int holds_done;
  bit calm;
  bit hold_req;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("multi_channel_pulse_counter_logger regression: fail");
    $finish;
  end

  initial begin
    counting_en = 1'b1;
    ring_wr     = '0;
    ring_fill   = '0;
    for (int i = 0; i < NCH; i++) begin
      cnt_live[i]  = '0;
      cnt_total[i] = '0;
      cnt_last[i]  = '0;
    end
  end

  function automatic mcpc_pkg::out_item_t make_result(input int ch, input logic [31:0] cnt,
                                                      input logic [63:0] tot,
                                                      input logic logged,
                                                      input logic [6:0] fill);
    mcpc_pkg::out_item_t r;
    r.out_channel = 2'(ch);
    r.count       = cnt;
    r.total       = tot;
    r.logged      = logged;
    r.log_fill    = fill;
    r.last        = (ch == NCH - 1);
    return r;
  endfunction

  function automatic void predict_counts(input mcpc_pkg::in_item_t it,
                                         ref mcpc_pkg::out_item_t res[$]);
    logic [5:0] slot;
    res.delete();
    case (it.operation)
      mcpc_pkg::OP_EDGE: begin
        if (counting_en) cnt_live[it.channel] = cnt_live[it.channel] + 32'd1;
      end
      mcpc_pkg::OP_CAPTURE: begin
        if (!counting_en) begin
          // disabled capture only clears the live counts
          for (int i = 0; i < NCH; i++) cnt_live[i] = '0;
        end else begin
          slot = ring_wr;
          for (int i = 0; i < NCH; i++) begin
            cnt_last[i]          = cnt_live[i];
            cnt_total[i]         = cnt_total[i] + {32'd0, cnt_live[i]};
            ring_counts[slot][i] = cnt_live[i];
            cnt_live[i]          = '0;
          end
          ring_uptime[slot] = it.boot_ms;
          ring_epoch[slot]  = it.epoch_seconds;
          ring_wr           = slot + 6'd1;
          if (ring_fill < RING_DEPTH) ring_fill = ring_fill + 7'd1;
          for (int i = 0; i < NCH; i++) begin
            res.push_back(make_result(i, cnt_last[i], cnt_total[i], 1'b1, ring_fill));
          end
          captures_logged++;
        end
      end
      mcpc_pkg::OP_PEEK: begin
        for (int i = 0; i < NCH; i++) begin
          res.push_back(make_result(i, cnt_live[i], cnt_total[i], 1'b0, ring_fill));
        end
      end
      default: ;
    endcase
  endfunction

  function automatic mcpc_pkg::in_item_t rand_item(input int unsigned w_edge,
                                                   input int unsigned w_cap,
                                                   input int unsigned w_peek);
    mcpc_pkg::in_item_t it;
    logic [63:0]        w;
    int unsigned        r;
    r = $urandom_range(0, 99);
    if (r < w_edge) it.operation = mcpc_pkg::OP_EDGE;
    else if (r < w_edge + w_cap) it.operation = mcpc_pkg::OP_CAPTURE;
    else if (r < w_edge + w_cap + w_peek) it.operation = mcpc_pkg::OP_PEEK;
    else it.operation = OP_UNUSED;
    it.channel       = 2'($urandom_range(0, 3));
    w                = {$urandom, $urandom};
    it.boot_ms       = w[47:0];
    it.epoch_seconds = $urandom;
    return it;
  endfunction

  function automatic dir_row_t row_item(input logic [1:0] op, input logic [1:0] ch,
                                        input logic [47:0] up, input logic [31:0] ep);
    dir_row_t row;
    row.kind                  = ROW_ITEM;
    row.item.operation        = op;
    row.item.channel          = ch;
    row.item.boot_ms          = up;
    row.item.epoch_seconds    = ep;
    row.typed                 = 1'b0;
    row.tmpl                  = '0;
    row.addr                  = '0;
    row.wdata                 = '0;
    return row;
  endfunction

  function automatic dir_row_t row_typed(input logic [1:0] op, input logic [47:0] up,
                                         input logic [31:0] ep, input logic [31:0] cnt,
                                         input logic [63:0] tot, input logic logged,
                                         input logic [6:0] fill);
    dir_row_t row;
    row       = row_item(op, 2'd0, up, ep);
    row.typed = 1'b1;
    row.tmpl  = make_result(0, cnt, tot, logged, fill);
    return row;
  endfunction

  function automatic dir_row_t row_reg(input logic [2:0] addr, input logic [31:0] data);
    dir_row_t row;
    row       = row_item(mcpc_pkg::OP_EDGE, 2'd0, '0, '0);
    row.kind  = ROW_REG;
    row.addr  = addr;
    row.wdata = data;
    return row;
  endfunction

  task automatic send_item(input mcpc_pkg::in_item_t it, input logic use_tmpl,
                           input mcpc_pkg::out_item_t tmpl);
    mcpc_pkg::out_item_t res[$];
    mcpc_pkg::out_item_t e;
    push   <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_counts(it, res);
    foreach (res[i]) begin
      e = res[i];
      if (use_tmpl) begin
        e             = tmpl;
        e.out_channel = 2'(i);
        e.last        = (i == NCH - 1);
      end
      pending_results.push_back(e);
    end
    items_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    push <= 1'b0;
    // let queued edges drain out of the command queue too
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == ADDR_ENABLE) counting_en = data[0];
    reg_writes++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == ADDR_ENABLE && prdata[0] !== counting_en) begin
      $error("counting_enabled readback: expected %0d, actual %0d", counting_en, prdata[0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    pop <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        holds_done++;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    mcpc_pkg::out_item_t e;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: channel %0d count %0d",
               result_o.out_channel, result_o.count);
        errors++;
      end else begin
        e = pending_results.pop_front();
        results_checked++;
        if (result_o.out_channel !== e.out_channel) begin
          $error("out_channel: expected %0d, actual %0d", e.out_channel, result_o.out_channel);
          errors++;
        end
        if (result_o.count !== e.count) begin
          $error("count: expected %0d, actual %0d", e.count, result_o.count);
          errors++;
        end
        if (result_o.total !== e.total) begin
          $error("total: expected %0d, actual %0d", e.total, result_o.total);
          errors++;
        end
        if (result_o.logged !== e.logged) begin
          $error("logged: expected %0d, actual %0d", e.logged, result_o.logged);
          errors++;
        end
        if (result_o.log_fill !== e.log_fill) begin
          $error("log_fill: expected %0d, actual %0d", e.log_fill, result_o.log_fill);
          errors++;
        end
        if (result_o.last !== e.last) begin
          $error("last: expected %0d, actual %0d", e.last, result_o.last);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [1:0] phase_en [4];
    rst_ni  <= 1'b0;
    push    <= 1'b0;
    item_i  <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reset state, field extremes, every operation, disabled behavior
    dir_rows.push_back(row_typed(mcpc_pkg::OP_PEEK, '0, '0, 32'd0, 64'd0, 1'b0, 7'd0));
    dir_rows.push_back(row_typed(mcpc_pkg::OP_CAPTURE, '0, '0, 32'd0, 64'd0, 1'b1, 7'd1));
    for (int c = 0; c < NCH; c++) begin
      dir_rows.push_back(row_item(mcpc_pkg::OP_EDGE, 2'(c), 48'hFFFF_FFFF_FFFF,
                                  32'hFFFF_FFFF));
    end
    dir_rows.push_back(row_typed(mcpc_pkg::OP_CAPTURE, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                                 32'd1, 64'd1, 1'b1, 7'd2));
    dir_rows.push_back(row_item(mcpc_pkg::OP_EDGE, 2'd3, 48'h1234_5678_9ABC, 32'h0F0F_0F0F));
    dir_rows.push_back(row_item(mcpc_pkg::OP_EDGE, 2'd1, 48'h0, 32'h0));
    dir_rows.push_back(row_item(OP_UNUSED, 2'd2, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
    dir_rows.push_back(row_item(mcpc_pkg::OP_PEEK, 2'd0, 48'h0, 32'h0));
    dir_rows.push_back(row_item(mcpc_pkg::OP_CAPTURE, 2'd3, 48'hA5A5_A5A5_A5A5,
                                32'h5A5A_5A5A));
    dir_rows.push_back(row_item(mcpc_pkg::OP_EDGE, 2'd0, 48'h0, 32'h0));
    dir_rows.push_back(row_item(mcpc_pkg::OP_EDGE, 2'd2, 48'h0, 32'h0));
    dir_rows.push_back(row_reg(ADDR_UNMAPPED, 32'h0));
    dir_rows.push_back(row_item(mcpc_pkg::OP_EDGE, 2'd0, 48'h0, 32'h0));
    dir_rows.push_back(row_reg(ADDR_ENABLE, 32'h0));
    // disabling keeps the counts until the next capture
    dir_rows.push_back(row_item(mcpc_pkg::OP_PEEK, 2'd0, 48'h0, 32'h0));
    dir_rows.push_back(row_item(mcpc_pkg::OP_EDGE, 2'd1, 48'h0, 32'h0));
    dir_rows.push_back(row_item(mcpc_pkg::OP_CAPTURE, 2'd0, 48'hFFFF_FFFF_FFFF,
                                32'hFFFF_FFFF));
    dir_rows.push_back(row_item(mcpc_pkg::OP_PEEK, 2'd0, 48'h0, 32'h0));
    dir_rows.push_back(row_reg(ADDR_ENABLE, 32'hFFFF_FFFF));
    dir_rows.push_back(row_item(mcpc_pkg::OP_EDGE, 2'd2, 48'h0, 32'h0));
    dir_rows.push_back(row_item(mcpc_pkg::OP_PEEK, 2'd0, 48'h0, 32'h0));

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_REG) reg_write(dir_rows[r].addr, dir_rows[r].wdata);
      else send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].tmpl);
    end

    // Hold the receiver off while captures keep arriving, so the block backs up
    hold_req = 1'b1;
    for (int n = 0; n < 30; n++) send_item(rand_item(15, 60, 25), 1'b0, '0);

    phase_en[0] = 2'd1;
    phase_en[1] = 2'd0;
    phase_en[2] = 2'd1;
    phase_en[3] = 2'd1;
    for (int p = 0; p < 4; p++) begin
      reg_write(ADDR_ENABLE, {30'd0, phase_en[p]});
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n >= 15) calm = 1'b1;
        send_item(rand_item(60, 22, 14), 1'b0, '0);
      end
    end

    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d items, %0d results checked, %0d logged captures (ring fill %0d)",
             items_sent, results_checked, captures_logged, ring_fill);
    $display("register writes %0d, long receiver hold-offs %0d", reg_writes, holds_done);
    if (errors == 0) begin
      $display("multi_channel_pulse_counter_logger regression: pass");
    end else begin
      $display("multi_channel_pulse_counter_logger regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/mcpc_pkg.sv
rtl/core/mcpc_front.sv
rtl/core/mcpc_back.sv
rtl/core/multi_channel_pulse_counter_logger.sv
verif/testbench.sv
